// ===== src/yyat_pkg.sv =====
// Types, constants and step functions for the Yin-Yang angle transform pipeline.
`timescale 1ns / 1ps
package yyat_pkg;

   localparam int FRAC_BITS = 16;
   localparam int IQ = 30;
   localparam int STEPS = 31;
   localparam int SH = IQ - FRAC_BITS;

   localparam logic signed [35:0] PI_Q = 36'sd3373259426;
   localparam logic signed [35:0] TWO_PI_Q = 36'sd6746518852;
   localparam logic signed [35:0] HALF_PI_Q = 36'sd1686629713;
   localparam logic signed [35:0] ONE_Q = 36'sd1073741824;
   localparam logic signed [33:0] GAIN_Q = 34'sd652032874;
   localparam logic signed [63:0] HALF_LSB_Q = 64'sd1 <<< (IQ - 1);

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] r;
      logic               neg;
   } rot_type;

   typedef struct packed {
      logic [60:0] rem;
      logic [30:0] res;
      logic [30:0] ax;
      logic        xneg;
   } sq_type;

   typedef struct packed {
      logic signed [33:0] ax;
      logic signed [33:0] y;
      logic signed [33:0] z;
      logic               xneg;
   } vec_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [29:0] q;
      logic [30:0] dvs;
      logic        bneg;
      logic        forced;
      logic        ctle;
   } div_type;

   typedef struct packed {
      logic [17:0] tp;
      logic        forced;
      logic        ctle;
   } side_type;

   function automatic logic [29:0] arc_tab(input int i);
      logic [29:0] t;
      case (i)
         0: t = 30'd843314857;
         1: t = 30'd497837829;
         2: t = 30'd263043837;
         3: t = 30'd133525159;
         4: t = 30'd67021687;
         5: t = 30'd33543516;
         6: t = 30'd16775851;
         7: t = 30'd8388437;
         8: t = 30'd4194283;
         9: t = 30'd2097149;
         default: t = 30'(1) << (IQ - i);
      endcase
      return t;
   endfunction

   function automatic rot_type reduce(input logic signed [35:0] a);
      rot_type o;
      logic signed [35:0] r;
      r = a;
      o.neg = 1'b0;
      if (r > PI_Q) r = r - TWO_PI_Q;
      else if (r <= -PI_Q) r = r + TWO_PI_Q;
      if (r > HALF_PI_Q) begin
         r = r - PI_Q;
         o.neg = 1'b1;
      end else if (r < -HALF_PI_Q) begin
         r = r + PI_Q;
         o.neg = 1'b1;
      end
      o.r = 34'(r);
      o.x = GAIN_Q;
      o.y = '0;
      return o;
   endfunction

   function automatic rot_type rot_step(input rot_type s, input int i);
      rot_type o;
      logic signed [33:0] t;
      t = signed'(34'(arc_tab(i)));
      o = s;
      if (s.r >= 0) begin
         o.x = s.x - (s.y >>> i);
         o.y = s.y + (s.x >>> i);
         o.r = s.r - t;
      end else begin
         o.x = s.x + (s.y >>> i);
         o.y = s.y - (s.x >>> i);
         o.r = s.r + t;
      end
      return o;
   endfunction

   function automatic logic signed [31:0] fin_trig(input rot_type s, input logic sel_sin);
      logic signed [35:0] v;
      v = sel_sin ? 36'(s.y) : 36'(s.x);
      if (s.neg) v = -v;
      if (v > ONE_Q) v = ONE_Q;
      else if (v < -ONE_Q) v = -ONE_Q;
      return 32'(v);
   endfunction

   function automatic logic signed [31:0] mul_q(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b) + HALF_LSB_Q;
      return 32'(p >>> IQ);
   endfunction

   function automatic sq_type sq_init(input logic [30:0] mag, input logic xneg);
      sq_type o;
      logic [61:0] prod;
      prod = 62'(mag) * 62'(mag);
      o.rem = 61'((62'(1) << (2 * IQ)) - prod);
      o.res = '0;
      o.ax = mag;
      o.xneg = xneg;
      return o;
   endfunction

   function automatic sq_type sqrt_step(input sq_type s, input int b);
      sq_type o;
      logic [61:0] trial;
      o = s;
      trial = (62'(s.res) << (b + 1)) | (62'(1) << (2 * b));
      if (62'(s.rem) >= trial) begin
         o.rem = 61'(62'(s.rem) - trial);
         o.res[b] = 1'b1;
      end
      return o;
   endfunction

   function automatic vec_type vec_init(input sq_type s);
      vec_type o;
      o.ax = 34'(s.ax);
      o.y = 34'(s.res);
      o.z = '0;
      o.xneg = s.xneg;
      return o;
   endfunction

   function automatic vec_type vec_step(input vec_type s, input int i);
      vec_type o;
      logic signed [33:0] t;
      t = signed'(34'(arc_tab(i)));
      o = s;
      if (s.y > 0) begin
         o.ax = s.ax + (s.y >>> i);
         o.y = s.y - (s.ax >>> i);
         o.z = s.z + t;
      end else begin
         o.ax = s.ax - (s.y >>> i);
         o.y = s.y + (s.ax >>> i);
         o.z = s.z - t;
      end
      return o;
   endfunction

   function automatic logic signed [35:0] acos_fin(input vec_type v);
      logic signed [35:0] z;
      z = 36'(v.z);
      if (z < 0) z = '0;
      else if (z > HALF_PI_Q) z = HALF_PI_Q;
      return v.xneg ? PI_Q - z : z;
   endfunction

   function automatic logic signed [21:0] to_out(input logic signed [35:0] v);
      logic signed [35:0] t;
      t = v + (36'sd1 <<< (SH - 1));
      return 22'(t >>> SH);
   endfunction

   function automatic div_type div_init(input logic signed [31:0] b, input logic [30:0] s,
                                        input logic ctle);
      div_type o;
      logic [30:0] mag;
      mag = 31'(b < 0 ? -b : b);
      o.rem = 32'(mag);
      o.q = '0;
      o.dvs = s;
      o.bneg = b < 0;
      o.forced = mag >= s;
      o.ctle = ctle;
      return o;
   endfunction

   function automatic div_type div_step(input div_type s, input int j);
      div_type o;
      logic [32:0] t;
      o = s;
      t = {s.rem, 1'b0};
      if (t >= 33'(s.dvs)) begin
         o.rem = 32'(t - 33'(s.dvs));
         o.q[j] = 1'b1;
      end else begin
         o.rem = 32'(t);
      end
      return o;
   endfunction

endpackage

// ===== src/yin_yang_angle_transform.sv =====
// Yin-Yang grid angle transform: fully pipelined CORDIC, square root and divider chain.
`timescale 1ns / 1ps
// Maps a grid point (theta, phi) in Q.16 radians to the complementary grid. One beat is
// accepted every cycle while the output is not stalled; the pipeline is the chain of
// one-step-per-stage units: two 31-stage rotation CORDICs in parallel, a 31-stage
// square root, a 31-stage vectoring CORDIC beside a 30-stage divider, then a second square
// root and vectoring CORDIC. A stall at the output holds the whole pipeline.
module yin_yang_angle_transform (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // theta[17:0], phi[36:18], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // theta_prim[17:0], phi_prim[36:18], zero fill
   output logic [0:0]  rsp_tuser    // phi_forced_zero[0]
);

   localparam int STEPS = yyat_pkg::STEPS;
   localparam int LAT = 5 * (STEPS + 1) + 3;

   logic [LAT-1:0] vld_ff;
   logic adv;

   logic signed [35:0] th_q;
   logic signed [35:0] ph_q;

   yyat_pkg::rot_type  rot_th_ff [0:STEPS];
   yyat_pkg::rot_type  rot_ph_ff [0:STEPS];
   logic signed [31:0] st_ff, ct_ff, sp_ff, cp_ff;
   logic signed [31:0] a_ff, b_ff;
   logic               ctle_ff;
   yyat_pkg::sq_type   sq1_ff [0:STEPS];
   logic signed [31:0] b1_ff [0:STEPS];
   logic               ctle1_ff [0:STEPS];
   yyat_pkg::vec_type  vec1_ff [0:STEPS];
   yyat_pkg::div_type  div_ff [0:STEPS-1];
   yyat_pkg::div_type  xr_ff;
   yyat_pkg::sq_type   sq2_ff [0:STEPS];
   yyat_pkg::vec_type  vec2_ff [0:STEPS];
   yyat_pkg::side_type side2_ff [0:2*STEPS+1];
   logic [17:0]        rsp_theta_ff;
   logic [18:0]        rsp_phi_ff;
   logic               rsp_forced_ff;

   logic signed [35:0] pp_q;
   logic signed [21:0] pp_out;
   logic signed [21:0] tp_out;

   assign adv = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata = {3'b000, rsp_phi_ff, rsp_theta_ff};
   assign rsp_tuser = rsp_forced_ff;

   assign th_q = signed'(36'(req_tdata[17:0]) << yyat_pkg::SH);
   assign ph_q = 36'(signed'(req_tdata[36:18])) <<< yyat_pkg::SH;

   always_comb begin
      tp_out = yyat_pkg::to_out(yyat_pkg::acos_fin(vec1_ff[STEPS]));
      pp_q = yyat_pkg::acos_fin(vec2_ff[STEPS]);
      if (side2_ff[2*STEPS+1].ctle) pp_q = -pp_q;
      pp_out = yyat_pkg::to_out(pp_q);
      if (side2_ff[2*STEPS+1].forced) pp_out = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rot_th_ff[0] <= yyat_pkg::reduce(th_q);
         rot_ph_ff[0] <= yyat_pkg::reduce(ph_q);
         for (int k = 0; k < STEPS; k++) begin
            rot_th_ff[k+1] <= yyat_pkg::rot_step(rot_th_ff[k], k);
            rot_ph_ff[k+1] <= yyat_pkg::rot_step(rot_ph_ff[k], k);
         end

         st_ff <= yyat_pkg::fin_trig(rot_th_ff[STEPS], 1'b1);
         ct_ff <= yyat_pkg::fin_trig(rot_th_ff[STEPS], 1'b0);
         sp_ff <= yyat_pkg::fin_trig(rot_ph_ff[STEPS], 1'b1);
         cp_ff <= yyat_pkg::fin_trig(rot_ph_ff[STEPS], 1'b0);

         a_ff <= yyat_pkg::mul_q(st_ff, sp_ff);
         b_ff <= yyat_pkg::mul_q(st_ff, cp_ff);
         ctle_ff <= ct_ff <= 0;

         sq1_ff[0] <= yyat_pkg::sq_init(31'(a_ff < 0 ? -a_ff : a_ff), a_ff < 0);
         b1_ff[0] <= b_ff;
         ctle1_ff[0] <= ctle_ff;
         for (int k = 0; k < STEPS; k++) begin
            sq1_ff[k+1] <= yyat_pkg::sqrt_step(sq1_ff[k], STEPS - 1 - k);
            b1_ff[k+1] <= b1_ff[k];
            ctle1_ff[k+1] <= ctle1_ff[k];
         end

         vec1_ff[0] <= yyat_pkg::vec_init(sq1_ff[STEPS]);
         div_ff[0] <= yyat_pkg::div_init(b1_ff[STEPS], sq1_ff[STEPS].res, ctle1_ff[STEPS]);
         for (int k = 0; k < STEPS; k++) begin
            vec1_ff[k+1] <= yyat_pkg::vec_step(vec1_ff[k], k);
         end
         for (int k = 0; k < STEPS - 1; k++) begin
            div_ff[k+1] <= yyat_pkg::div_step(div_ff[k], STEPS - 2 - k);
         end
         xr_ff <= div_ff[STEPS-1];

         sq2_ff[0] <= yyat_pkg::sq_init(31'(xr_ff.q), !xr_ff.bneg && (xr_ff.q != '0));
         side2_ff[0] <= '{tp: tp_out[17:0], forced: xr_ff.forced, ctle: xr_ff.ctle};
         for (int k = 0; k < STEPS; k++) begin
            sq2_ff[k+1] <= yyat_pkg::sqrt_step(sq2_ff[k], STEPS - 1 - k);
            vec2_ff[k+1] <= yyat_pkg::vec_step(vec2_ff[k], k);
         end
         vec2_ff[0] <= yyat_pkg::vec_init(sq2_ff[STEPS]);
         for (int k = 0; k < 2 * STEPS + 1; k++) begin
            side2_ff[k+1] <= side2_ff[k];
         end

         rsp_theta_ff <= side2_ff[2*STEPS+1].tp;
         rsp_phi_ff <= pp_out[18:0];
         rsp_forced_ff <= side2_ff[2*STEPS+1].forced;
      end
   end

   a_forced_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[36:18] == 19'd0)
      else $error("forced beat carries nonzero phi_prim");

   a_theta_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[17:0] <= 18'd205887)
      else $error("theta_prim beyond pi");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(vld_ff))
      else $error("pipeline moved during stall");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted beat missing from first stage");

endmodule
